// ===== rtl/core/bba_pkg.sv =====
package bba_pkg;

  localparam int MAX_BLOCK_COUNT_DEF = 2048;

  localparam int CNT_W  = 12;
  localparam int IDX_W  = 11;
  localparam int ST_W   = 2;
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic REG_NUM_BLOCKS = 1'b0;
  localparam logic [CNT_W-1:0] NUM_BLOCKS_RST = 12'd2048;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK           = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_FREE      = 2'd1;
  localparam logic [ST_W-1:0] ST_INVALID      = 2'd2;
  localparam logic [ST_W-1:0] ST_ALREADY_FREE = 2'd3;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } ffz_res_t;

endpackage

// ===== rtl/core/bba_ram.sv =====
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bba_ffz.sv =====
module bba_ffz (
  input  logic [bba_pkg::WORD_W-1:0] word,
  input  logic                       last,
  input  logic [bba_pkg::BIT_W-1:0]  lim,
  output bba_pkg::ffz_res_t          res
);

  logic [bba_pkg::WORD_W-1:0] avail;

  always_comb begin
    for (int b = 0; b < bba_pkg::WORD_W; b++) begin
      avail[b] = !word[b] && (!last || (bba_pkg::BIT_W'(b) <= lim));
    end
    res.found = |avail;
    res.pos   = '0;
    for (int b = bba_pkg::WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        res.pos = bba_pkg::BIT_W'(b);
      end
    end
  end

endmodule

// ===== rtl/core/bitmap_block_allocator.sv =====
// Allocate: map words are scanned from word 0 up; the lowest free block is granted,
//   or no free block is reported once the last 32-bit map word holds none.
// Free: map word read, then bit cleared if set; invalid index or zero block count: result without a map access.
// One item at a time; in_stall is high from accept until the result is registered.
// Reset: synchronous; a clearing pass writes ceil(MAX_BLOCK_COUNT/32) map words
//   (64 at the default depth) with in_stall high.
module bitmap_block_allocator #(
  parameter int MAX_BLOCK_COUNT = bba_pkg::MAX_BLOCK_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic [bba_pkg::IDX_W-1:0]   block_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bba_pkg::ST_W-1:0]    status,
  output logic [bba_pkg::IDX_W-1:0]   granted_index,
  output logic [bba_pkg::CNT_W-1:0]   used_blocks,
  output logic [bba_pkg::CNT_W-1:0]   free_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bba_pkg::APB_AW-1:0]  paddr,
  input  logic [bba_pkg::APB_DW-1:0]  pwdata,
  output logic [bba_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int Words = (MAX_BLOCK_COUNT + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
  localparam int WaW   = (Words > 1) ? $clog2(Words) : 1;
  localparam int MaxW  = $clog2(MAX_BLOCK_COUNT + 1);
  localparam int ExtW  = (MaxW > bba_pkg::CNT_W) ? MaxW : bba_pkg::CNT_W;
  localparam int CW    = bba_pkg::CNT_W;
  localparam int BW    = bba_pkg::BIT_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FEV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                    state, state_next;
  logic [CW-1:0]                 nb;
  logic [CW-1:0]                 used_total, used_total_next;
  logic [WaW-1:0]                ptr, ptr_next;
  logic [WaW-1:0]                eval_ptr, eval_ptr_next;
  logic                          eval_vld, eval_vld_next;
  logic [WaW-1:0]                clr_ptr, clr_ptr_next;
  logic [bba_pkg::IDX_W-1:0]     op_idx, op_idx_next;
  logic [bba_pkg::ST_W-1:0]      res_status, res_status_next;
  logic [bba_pkg::IDX_W-1:0]     res_grant, res_grant_next;
  logic                          out_valid_next;

  logic                          we;
  logic [WaW-1:0]                waddr, raddr;
  logic [bba_pkg::WORD_W-1:0]    wdata, rdata;

  logic [CW-1:0]                 n, n_m1;
  logic [WaW-1:0]                last_word;
  logic [WaW-1:0]                op_word;
  logic [BW-1:0]                 op_bit;
  bba_pkg::ffz_res_t             ffz;
  logic                          cfg_we;

  assign n = (ExtW'(nb) > ExtW'(MAX_BLOCK_COUNT)) ? CW'(MAX_BLOCK_COUNT) : nb;
  assign n_m1      = n - CW'(1);
  assign last_word = WaW'(n_m1 >> BW);
  assign op_word   = WaW'(op_idx >> BW);
  assign op_bit    = op_idx[BW-1:0];

  assign in_stall = (state != S_IDLE);

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready
                  && (paddr[2] == bba_pkg::REG_NUM_BLOCKS);
  assign prdata = (paddr[2] == bba_pkg::REG_NUM_BLOCKS)
                  ? bba_pkg::APB_DW'(nb) : '0;

  bba_ram #(
    .WIDTH (bba_pkg::WORD_W),
    .DEPTH (Words)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  bba_ffz u_ffz (
    .word (rdata),
    .last (eval_ptr == last_word),
    .lim  (n_m1[BW-1:0]),
    .res  (ffz)
  );

  always_comb begin
    state_next      = state;
    used_total_next = used_total;
    ptr_next        = ptr;
    eval_ptr_next   = eval_ptr;
    eval_vld_next   = eval_vld;
    clr_ptr_next    = clr_ptr;
    op_idx_next     = op_idx;
    res_status_next = res_status;
    res_grant_next  = res_grant;
    out_valid_next  = out_valid && out_stall;
    we              = 1'b0;
    waddr           = clr_ptr;
    wdata           = '0;
    raddr           = ptr;
    case (state)
      S_CLEAR: begin
        we           = 1'b1;
        clr_ptr_next = clr_ptr + WaW'(1);
        if (clr_ptr == WaW'(Words - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_idx_next     = block_index;
          res_grant_next  = '0;
          res_status_next = bba_pkg::ST_OK;
          if (opcode == bba_pkg::OP_ALLOC) begin
            if (n == '0) begin
              res_status_next = bba_pkg::ST_NO_FREE;
              state_next      = S_DONE;
            end else begin
              ptr_next      = '0;
              eval_vld_next = 1'b0;
              state_next    = S_SCAN;
            end
          end else begin
            if ({1'b0, block_index} >= n) begin
              res_status_next = bba_pkg::ST_INVALID;
              state_next      = S_DONE;
            end else begin
              raddr      = WaW'(block_index >> BW);
              state_next = S_FEV;
            end
          end
        end
      end
      S_SCAN: begin
        ptr_next      = ptr + WaW'(1);
        eval_ptr_next = ptr;
        eval_vld_next = 1'b1;
        if (eval_vld) begin
          if (ffz.found) begin
            we              = 1'b1;
            waddr           = eval_ptr;
            wdata           = rdata | (bba_pkg::WORD_W'(1) << ffz.pos);
            used_total_next = used_total + CW'(1);
            res_status_next = bba_pkg::ST_OK;
            res_grant_next  = bba_pkg::IDX_W'({eval_ptr, ffz.pos});
            state_next      = S_DONE;
          end else if (eval_ptr == last_word) begin
            res_status_next = bba_pkg::ST_NO_FREE;
            state_next      = S_DONE;
          end
        end
      end
      S_FEV: begin
        if (rdata[op_bit]) begin
          we    = 1'b1;
          waddr = op_word;
          wdata = rdata & ~(bba_pkg::WORD_W'(1) << op_bit);
          if (used_total != '0) begin
            used_total_next = used_total - CW'(1);
          end
          res_status_next = bba_pkg::ST_OK;
        end else begin
          res_status_next = bba_pkg::ST_ALREADY_FREE;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_ptr    <= '0;
      used_total <= '0;
      nb         <= bba_pkg::NUM_BLOCKS_RST;
      out_valid  <= 1'b0;
      eval_vld   <= 1'b0;
    end else begin
      state      <= state_next;
      clr_ptr    <= clr_ptr_next;
      used_total <= used_total_next;
      out_valid  <= out_valid_next;
      eval_vld   <= eval_vld_next;
      if (cfg_we) begin
        nb <= pwdata[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    eval_ptr   <= eval_ptr_next;
    op_idx     <= op_idx_next;
    res_status <= res_status_next;
    res_grant  <= res_grant_next;
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      status        <= res_status;
      granted_index <= res_grant;
      used_blocks   <= used_total;
      free_count    <= (n > used_total) ? (n - used_total) : '0;
    end
  end

endmodule

// ===== rtl/core/bba_chk.sv =====
module bba_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [bba_pkg::ST_W-1:0]   status,
  input logic [bba_pkg::IDX_W-1:0]  granted_index,
  input logic [bba_pkg::CNT_W-1:0]  used_blocks,
  input logic [bba_pkg::CNT_W-1:0]  free_count
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted item did not make the block busy");

  a_grant_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bba_pkg::ST_OK |-> granted_index == '0)
    else $error("nonzero granted_index on failed request");

  a_no_free_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == bba_pkg::ST_NO_FREE |-> free_count == '0)
    else $error("no free block reported with nonzero free_count");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status)
      && $stable(granted_index) && $stable(used_blocks) && $stable(free_count))
    else $error("stalled result changed");

endmodule

bind bitmap_block_allocator bba_chk u_bba_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .granted_index (granted_index),
  .used_blocks   (used_blocks),
  .free_count    (free_count)
);

// ===== tb/sv/tb_bitmap_block_allocator.sv =====
module tb_bitmap_block_allocator;

  localparam int MAP_DEPTH      = bba_pkg::MAX_BLOCK_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 4;
  localparam logic [bba_pkg::APB_AW-1:0] ADDR_NUM_BLOCKS =
    bba_pkg::APB_AW'(bba_pkg::REG_NUM_BLOCKS) << 2;

  typedef struct packed {
    logic [bba_pkg::ST_W-1:0]  status;
    logic [bba_pkg::IDX_W-1:0] grant;
    logic [bba_pkg::CNT_W-1:0] used;
    logic [bba_pkg::CNT_W-1:0] free;
  } alloc_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       opcode = bba_pkg::OP_ALLOC;
  logic [bba_pkg::IDX_W-1:0]  block_index = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [bba_pkg::ST_W-1:0]   status;
  logic [bba_pkg::IDX_W-1:0]  granted_index;
  logic [bba_pkg::CNT_W-1:0]  used_blocks;
  logic [bba_pkg::CNT_W-1:0]  free_count;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [bba_pkg::APB_AW-1:0] paddr = '0;
  logic [bba_pkg::APB_DW-1:0] pwdata = '0;
  logic [bba_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  // allocator shadow state
  bit                        blk_used [MAP_DEPTH];
  logic [bba_pkg::CNT_W-1:0] blk_used_total;
  logic [bba_pkg::CNT_W-1:0] cfg_num_blocks;

  alloc_result_t expected_results [$];
  alloc_result_t seen_result;
  alloc_result_t due_result;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int          idle_cycles = 0;
  int          n_fail = 0;
  int          n_shown = 0;

  bitmap_block_allocator #(.MAX_BLOCK_COUNT(MAP_DEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .block_index(block_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .granted_index(granted_index),
    .used_blocks(used_blocks),
    .free_count(free_count),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int eff_block_count();
    return (int'(cfg_num_blocks) > MAP_DEPTH) ? MAP_DEPTH : int'(cfg_num_blocks);
  endfunction

  function automatic alloc_result_t model_request(input logic op,
                                                  input logic [bba_pkg::IDX_W-1:0] idx);
    alloc_result_t r;
    int n;
    int i;
    bit found;
    n = eff_block_count();
    r = '0;
    r.status = bba_pkg::ST_OK;
    found = 1'b0;
    if (op == bba_pkg::OP_ALLOC) begin
      for (i = 0; i < n; i++) begin
        if (!found && !blk_used[i]) begin
          found = 1'b1;
          blk_used[i] = 1'b1;
          blk_used_total = blk_used_total + bba_pkg::CNT_W'(1);
          r.grant = bba_pkg::IDX_W'(i);
        end
      end
      if (!found) r.status = bba_pkg::ST_NO_FREE;
    end else if (int'(idx) >= n) begin
      r.status = bba_pkg::ST_INVALID;
    end else if (!blk_used[idx]) begin
      r.status = bba_pkg::ST_ALREADY_FREE;
    end else begin
      blk_used[idx] = 1'b0;
      if (blk_used_total != '0) blk_used_total = blk_used_total - bba_pkg::CNT_W'(1);
    end
    r.used = blk_used_total;
    r.free = (n > int'(blk_used_total)) ? bba_pkg::CNT_W'(n - int'(blk_used_total)) : '0;
    return r;
  endfunction

  task automatic send_request(input logic op, input logic [bba_pkg::IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    block_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(model_request(op, idx));
  endtask

  task automatic wait_drained(input int extra);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic apb_write(input logic [bba_pkg::APB_AW-1:0] addr,
                           input logic [bba_pkg::APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_block_count(input logic [bba_pkg::CNT_W-1:0] value);
    wait_drained(SETTLE_CYCLES);
    apb_write(ADDR_NUM_BLOCKS, bba_pkg::APB_DW'(value));
    cfg_num_blocks = value;
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode % 4)
      0: begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      1: begin
        tx_idle_pct = 56;
        rx_stall_pct = 0;
      end
      2: begin
        tx_idle_pct = 0;
        rx_stall_pct = 56;
      end
      default: begin
        tx_idle_pct = 14;
        rx_stall_pct = 14;
      end
    endcase
  endtask

  // alloc, free of a used block, free of any block in range, free of any index
  task automatic send_random_request(input int alloc_pct);
    int n;
    int roll;
    int i;
    int in_use [$];
    logic [bba_pkg::IDX_W-1:0] idx;
    n = eff_block_count();
    roll = $urandom_range(0, 99);
    idx = bba_pkg::IDX_W'($urandom);
    if (roll < alloc_pct) begin
      send_request(bba_pkg::OP_ALLOC, idx);
    end else begin
      if (roll < alloc_pct + (100 - alloc_pct) * 2 / 3) begin
        for (i = 0; i < n; i++) begin
          if (blk_used[i]) in_use.push_back(i);
        end
        if (in_use.size() != 0) begin
          idx = bba_pkg::IDX_W'(in_use[$urandom_range(0, in_use.size() - 1)]);
        end
      end else if (roll < 95 && n > 0) begin
        idx = bba_pkg::IDX_W'($urandom_range(0, n - 1));
      end
      send_request(bba_pkg::OP_FREE, idx);
    end
  endtask

  task automatic run_phase(input logic [bba_pkg::CNT_W-1:0] count, input int items,
                           input int mode, input int alloc_pct);
    set_block_count(count);
    set_idle_mode(mode);
    repeat (items) send_random_request(alloc_pct);
  endtask

  task automatic test_directed();
    set_idle_mode(0);
    send_request(bba_pkg::OP_FREE, 11'd0);
    send_request(bba_pkg::OP_FREE, 11'd2047);
    send_request(bba_pkg::OP_ALLOC, 11'd2047);
    send_request(bba_pkg::OP_ALLOC, 11'd0);
    send_request(bba_pkg::OP_ALLOC, 11'h555);
    send_request(bba_pkg::OP_FREE, 11'd1);
    send_request(bba_pkg::OP_ALLOC, 11'h2aa);
    // count above map depth clamps
    set_block_count(12'hfff);
    send_request(bba_pkg::OP_ALLOC, 11'd0);
    send_request(bba_pkg::OP_FREE, 11'd2047);
    // lowered below blocks in use
    set_block_count(12'd2);
    send_request(bba_pkg::OP_FREE, 11'd2);
    send_request(bba_pkg::OP_ALLOC, 11'd0);
    // zero blocks
    set_block_count(12'd0);
    send_request(bba_pkg::OP_ALLOC, 11'd0);
    send_request(bba_pkg::OP_FREE, 11'd0);
    set_block_count(12'd1);
    send_request(bba_pkg::OP_FREE, 11'd0);
    send_request(bba_pkg::OP_ALLOC, 11'd0);
    send_request(bba_pkg::OP_ALLOC, 11'd0);
    set_block_count(12'd8);
    send_request(bba_pkg::OP_FREE, 11'd3);
    send_request(bba_pkg::OP_FREE, 11'd2);
    send_request(bba_pkg::OP_FREE, 11'd1);
    send_request(bba_pkg::OP_FREE, 11'd0);
    send_request(bba_pkg::OP_FREE, 11'd7);
  endtask

  task automatic test_random_mix();
    int counts [10] = '{1, 2, 3, 8, 31, 32, 33, 64, 100, 0};
    int p;
    for (p = 0; p < 10; p++) begin
      if (p == 9) counts[p] = $urandom_range(1, 4095);
      run_phase(bba_pkg::CNT_W'(counts[p]), 100, p, 55);
    end
  endtask

  task automatic test_large_map();
    run_phase(bba_pkg::NUM_BLOCKS_RST, 120, 0, 80);
    run_phase(12'd1500, 120, 3, 50);
  endtask

  task automatic test_output_hold();
    set_block_count(12'd48);
    set_idle_mode(0);
    hold_request = HOLD_CYCLES;
    repeat (60) send_random_request(55);
  endtask

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_result = {status, granted_index, used_blocks, free_count};
      if (expected_results.size() == 0) begin
        n_fail++;
        if (n_shown < 10) begin
          n_shown++;
          $display("unexpected result: status %0d index %0d used %0d free %0d",
                   status, granted_index, used_blocks, free_count);
        end
      end else begin
        due_result = expected_results.pop_front();
        if (seen_result !== due_result) begin
          n_fail++;
          if (n_shown < 10) begin
            n_shown++;
            $display("mismatch: expected status %0d index %0d used %0d free %0d",
                     due_result.status, due_result.grant, due_result.used, due_result.free);
            $display("          actual   status %0d index %0d used %0d free %0d",
                     status, granted_index, used_blocks, free_count);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    foreach (blk_used[i]) blk_used[i] = 1'b0;
    blk_used_total = '0;
    cfg_num_blocks = bba_pkg::NUM_BLOCKS_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix();
    test_large_map();
    test_output_hold();
    wait_drained(DRAIN_CYCLES);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== bitmap_block_allocator.f =====
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/bba_ffz.sv
rtl/core/bitmap_block_allocator.sv
rtl/core/bba_chk.sv
tb/sv/tb_bitmap_block_allocator.sv
